>>> rtl/kgd_pkg.sv
package kgd_pkg;

  localparam int unsigned ReqTypeW   = 1;
  localparam int unsigned KeyLevelsW = 3;
  localparam int unsigned KeySelW    = 2;
  localparam int unsigned FlagSelW   = 3;
  localparam int unsigned EvKeyW     = 2;
  localparam int unsigned EvCodeW    = 3;
  localparam int unsigned FlagW      = 7;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned TimerW     = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [PeriodW-1:0] SamplePeriodRst = 8'd20;
  localparam logic [TimerW-1:0]  LongPressRst    = 16'd1000;
  localparam logic [TimerW-1:0]  DoubleGapRst    = 16'd200;
  localparam logic [TimerW-1:0]  RepeatRst       = 16'd100;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_TICK  = 1'b0,
    REQ_CHECK = 1'b1
  } kgd_req_e;

  typedef enum logic [0:0] {
    RES_EVENT = 1'b0,
    RES_CHECK = 1'b1
  } kgd_res_e;

  typedef enum logic [FlagSelW-1:0] {
    FLAG_HOLD   = 3'd0,
    FLAG_DOWN   = 3'd1,
    FLAG_UP     = 3'd2,
    FLAG_SINGLE = 3'd3,
    FLAG_DOUBLE = 3'd4,
    FLAG_LONG   = 3'd5,
    FLAG_REPEAT = 3'd6
  } kgd_flag_e;

  typedef enum logic [EvCodeW-1:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_LONG   = 3'd2,
    EV_REPEAT = 3'd3,
    EV_SINGLE = 3'd4
  } kgd_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_LONG_PRESS    = 2'd1,
    CFG_DOUBLE_GAP    = 2'd2,
    CFG_REPEAT        = 2'd3
  } kgd_cfg_e;

  typedef struct packed {
    logic tick;
    logic check;
    logic scan;
    logic load_ev;
    logic ev_last;
  } kgd_cmd_t;

  typedef struct packed {
    logic sample;
    logic out_free;
    logic buf_empty;
    logic drain_end;
  } kgd_sts_t;

endpackage

>>> rtl/kgd_req_if.sv
interface kgd_req_if;
  import kgd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ReqTypeW-1:0]   req_type;
  logic [KeyLevelsW-1:0] key_levels;
  logic [KeySelW-1:0]    key_select;
  logic [FlagSelW-1:0]   flag_select;

  modport source (
    output valid, req_type, key_levels, key_select, flag_select,
    input  ready
  );

  modport sink (
    input  valid, req_type, key_levels, key_select, flag_select,
    output ready
  );
endinterface

>>> rtl/kgd_res_if.sv
interface kgd_res_if;
  import kgd_pkg::*;

  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [EvKeyW-1:0]  event_key;
  logic [EvCodeW-1:0] event_code;
  logic               check_hit;
  logic               last;

  modport source (
    output valid, result_kind, event_key, event_code, check_hit, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, event_key, event_code, check_hit, last,
    output ready
  );
endinterface

>>> rtl/kgd_ctrl.sv
module kgd_ctrl #(
  parameter int unsigned NUM_KEYS = 3,
  parameter int unsigned KeyW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [kgd_pkg::ReqTypeW-1:0] in_req_type_i,
  output logic                      in_ready_o,
  input  kgd_pkg::kgd_sts_t         sts_i,
  output kgd_pkg::kgd_cmd_t         cmd_o,
  output logic [KeyW-1:0]           key_idx_o,
  output logic [KeyW-1:0]           drain_idx_o
);
  import kgd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  localparam logic [KeyW-1:0] LastKey = KeyW'(NUM_KEYS - 1);

  state_e          state_q, state_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [KeyW-1:0] drain_q, drain_d;
  logic            acc;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    drain_d    = drain_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
    acc        = in_valid_i && in_ready_o;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (kgd_req_e'(in_req_type_i) == REQ_CHECK) begin
            cmd_o.check = 1'b1;
          end else begin
            cmd_o.tick = 1'b1;
            if (sts_i.sample) begin
              state_d = ST_SCAN;
              key_d   = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (key_q == LastKey) begin
          state_d = ST_DRAIN;
          drain_d = '0;
        end else begin
          key_d = key_q + KeyW'(1);
        end
      end
      ST_DRAIN: begin
        if (sts_i.buf_empty) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.load_ev = 1'b1;
          cmd_o.ev_last = sts_i.drain_end;
          if (sts_i.drain_end) begin
            state_d = ST_IDLE;
          end else begin
            drain_d = drain_q + KeyW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      key_q   <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      drain_q <= drain_d;
    end
  end

  assign key_idx_o   = key_q;
  assign drain_idx_o = drain_q;

endmodule

>>> rtl/kgd_dpath.sv
module kgd_dpath #(
  parameter int unsigned NUM_KEYS = 3,
  parameter int unsigned KeyW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
  parameter int unsigned CntW     = $clog2(NUM_KEYS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kgd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kgd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [kgd_pkg::KeyLevelsW-1:0] key_levels_i,
  input  logic [kgd_pkg::KeySelW-1:0]   key_select_i,
  input  logic [kgd_pkg::FlagSelW-1:0]  flag_select_i,
  input  kgd_pkg::kgd_cmd_t             cmd_i,
  input  logic [KeyW-1:0]               key_idx_i,
  input  logic [KeyW-1:0]               drain_idx_i,
  output kgd_pkg::kgd_sts_t             sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          result_kind_o,
  output logic [kgd_pkg::EvKeyW-1:0]    event_key_o,
  output logic [kgd_pkg::EvCodeW-1:0]   event_code_o,
  output logic                          check_hit_o,
  output logic                          last_o
);
  import kgd_pkg::*;

  typedef enum logic [2:0] {
    G_IDLE    = 3'd0,
    G_PRESSED = 3'd1,
    G_GAP     = 3'd2,
    G_SECOND  = 3'd3,
    G_REPEAT  = 3'd4
  } gest_e;

  logic [PeriodW-1:0] period_q;
  logic [TimerW-1:0]  long_q;
  logic [TimerW-1:0]  gap_q;
  logic [TimerW-1:0]  rep_q;
  logic [PeriodW-1:0] presc_q;
  logic [PeriodW-1:0] presc_inc;

  logic [NUM_KEYS-1:0] levels_q;
  logic [NUM_KEYS-1:0] last_lvl_q;
  gest_e               gest_q  [NUM_KEYS];
  logic [TimerW-1:0]   timer_q [NUM_KEYS];
  logic [FlagW-1:0]    flags_q [NUM_KEYS];

  logic [EvKeyW-1:0]   ev_key_q  [NUM_KEYS];
  kgd_event_e          ev_code_q [NUM_KEYS];
  logic [CntW-1:0]     ev_cnt_q;

  logic                out_valid_q;
  logic                kind_q;
  logic [EvKeyW-1:0]   key_q;
  logic [EvCodeW-1:0]  code_q;
  logic                hit_q;
  logic                last_q;

  logic [NUM_KEYS+KeyLevelsW-1:0] lvl_wide;
  logic [KeyW+KeySelW-1:0]        sel_wide;
  logic [KeyW+EvKeyW-1:0]         kidx_wide;
  logic [KeyW-1:0]                chk_idx;
  logic                           chk_ok;
  logic                           chk_hit;
  logic [FlagW:0]                 chk_vec;

  logic               cur, prev;
  logic [FlagW-1:0]   fl_n;
  gest_e              gs, gs_n;
  logic [TimerW-1:0]  tm, tm_n;
  logic               emit;
  kgd_event_e         code;

  assign presc_inc = presc_q + PeriodW'(1);
  assign lvl_wide  = {NUM_KEYS'(0), key_levels_i};
  assign sel_wide  = {KeyW'(0), key_select_i};
  assign kidx_wide = {EvKeyW'(0), key_idx_i};
  assign chk_idx   = sel_wide[KeyW-1:0];
  assign chk_ok    = (int'(key_select_i) < NUM_KEYS) && (flag_select_i <= FLAG_REPEAT);
  assign chk_vec   = {1'b0, flags_q[chk_idx]};
  assign chk_hit   = chk_ok && chk_vec[flag_select_i];

  assign sts_o.sample    = !(presc_inc < period_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.buf_empty = (ev_cnt_q == '0);
  assign sts_o.drain_end = ((CntW'(drain_idx_i) + CntW'(1)) == ev_cnt_q);

  always_comb begin
    cur  = levels_q[key_idx_i];
    prev = last_lvl_q[key_idx_i];
    fl_n = flags_q[key_idx_i];
    gs   = gest_q[key_idx_i];
    tm   = timer_q[key_idx_i];
    gs_n = gs;
    tm_n = tm;
    emit = 1'b0;
    code = EV_DOWN;
    fl_n[FLAG_HOLD] = cur;
    if (cur && !prev) begin
      fl_n[FLAG_DOWN] = 1'b1;
      emit = 1'b1;
      code = EV_DOWN;
    end
    if (!cur && prev) begin
      fl_n[FLAG_UP] = 1'b1;
      emit = 1'b1;
      code = EV_UP;
    end
    unique case (gs)
      G_IDLE: begin
        if (cur) begin
          tm_n = long_q;
          gs_n = G_PRESSED;
        end
      end
      G_PRESSED: begin
        if (!cur) begin
          tm_n = gap_q;
          gs_n = G_GAP;
        end else if (tm == '0) begin
          tm_n = rep_q;
          fl_n[FLAG_LONG] = 1'b1;
          emit = 1'b1;
          code = EV_LONG;
          gs_n = G_REPEAT;
        end
      end
      G_GAP: begin
        if (cur) begin
          fl_n[FLAG_DOUBLE] = 1'b1;
          gs_n = G_SECOND;
        end else if (tm == '0) begin
          fl_n[FLAG_SINGLE] = 1'b1;
          emit = 1'b1;
          code = EV_SINGLE;
          gs_n = G_IDLE;
        end
      end
      G_SECOND: begin
        if (!cur) begin
          gs_n = G_IDLE;
        end
      end
      G_REPEAT: begin
        if (!cur) begin
          gs_n = G_IDLE;
        end else if (tm == '0) begin
          tm_n = rep_q;
          fl_n[FLAG_REPEAT] = 1'b1;
          emit = 1'b1;
          code = EV_REPEAT;
        end
      end
      default: gs_n = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= SamplePeriodRst;
      long_q      <= LongPressRst;
      gap_q       <= DoubleGapRst;
      rep_q       <= RepeatRst;
      presc_q     <= '0;
      levels_q    <= '0;
      last_lvl_q  <= '0;
      ev_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        gest_q[k]  <= G_IDLE;
        timer_q[k] <= '0;
        flags_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (kgd_cfg_e'(cfg_idx_i))
          CFG_SAMPLE_PERIOD: period_q <= cfg_wdata_i[PeriodW-1:0];
          CFG_LONG_PRESS:    long_q   <= cfg_wdata_i[TimerW-1:0];
          CFG_DOUBLE_GAP:    gap_q    <= cfg_wdata_i[TimerW-1:0];
          CFG_REPEAT:        rep_q    <= cfg_wdata_i[TimerW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.tick) begin
        presc_q  <= sts_o.sample ? '0 : presc_inc;
        levels_q <= lvl_wide[NUM_KEYS-1:0];
        ev_cnt_q <= '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (timer_q[k] != '0) begin
            timer_q[k] <= timer_q[k] - TimerW'(1);
          end
        end
      end
      if (cmd_i.scan) begin
        last_lvl_q[key_idx_i] <= cur;
        gest_q[key_idx_i]     <= gs_n;
        timer_q[key_idx_i]    <= tm_n;
        flags_q[key_idx_i]    <= fl_n;
        if (emit) begin
          ev_cnt_q <= ev_cnt_q + CntW'(1);
        end
      end
      if (cmd_i.check && chk_hit && (flag_select_i != FLAG_HOLD)) begin
        flags_q[chk_idx][flag_select_i] <= 1'b0;
      end
      if (cmd_i.check || cmd_i.load_ev) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && emit) begin
      ev_key_q[ev_cnt_q[KeyW-1:0]]  <= kidx_wide[EvKeyW-1:0];
      ev_code_q[ev_cnt_q[KeyW-1:0]] <= code;
    end
    if (cmd_i.check) begin
      kind_q <= RES_CHECK;
      key_q  <= '0;
      code_q <= '0;
      hit_q  <= chk_hit;
      last_q <= 1'b1;
    end else if (cmd_i.load_ev) begin
      kind_q <= RES_EVENT;
      key_q  <= ev_key_q[drain_idx_i];
      code_q <= ev_code_q[drain_idx_i];
      hit_q  <= 1'b0;
      last_q <= cmd_i.ev_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign event_key_o   = key_q;
  assign event_code_o  = code_q;
  assign check_hit_o   = hit_q;
  assign last_o        = last_q;

endmodule

>>> rtl/key_gesture_detector_unit.sv
// Channel  | Direction | Payload                                          | Handshake
// req_i    | in        | req_type, key_levels, key_select, flag_select    | valid/ready
// res_o    | out       | result_kind, event_key, event_code, check_hit,   | valid/ready
//          |           | last                                             |
// cfg      | in        | cfg_idx_i, cfg_wdata_i                           | cfg_we_i
//
// A check's answer is registered as the request is accepted. A tick without a sample
// leaves the controller idle; a sampling tick visits one key per cycle, then enters
// the drain state even with no events, draining one per cycle while the output is free.
// All flags, timers, key states and the prescaler clear on the asynchronous reset.
// A stalled output holds the result register; requests wait while the controller
// is busy or the result register is full and not being taken.
module key_gesture_detector_unit #(
  parameter int unsigned NUM_KEYS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  kgd_req_if.sink                      req_i,
  kgd_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [kgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kgd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import kgd_pkg::*;

  localparam int unsigned KeyW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kgd_cmd_t        cmd;
  kgd_sts_t        sts;
  logic [KeyW-1:0] key_idx;
  logic [KeyW-1:0] drain_idx;

  kgd_ctrl #(
    .NUM_KEYS (NUM_KEYS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_req_type_i (req_i.req_type),
    .in_ready_o    (req_i.ready),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .key_idx_o     (key_idx),
    .drain_idx_o   (drain_idx)
  );

  kgd_dpath #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .key_levels_i  (req_i.key_levels),
    .key_select_i  (req_i.key_select),
    .flag_select_i (req_i.flag_select),
    .cmd_i         (cmd),
    .key_idx_i     (key_idx),
    .drain_idx_i   (drain_idx),
    .sts_o         (sts),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .result_kind_o (res_o.result_kind),
    .event_key_o   (res_o.event_key),
    .event_code_o  (res_o.event_code),
    .check_hit_o   (res_o.check_hit),
    .last_o        (res_o.last)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import kgd_pkg::*;

  localparam int unsigned NUM_KEYS    = 3;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned LONG_HOLD   = 150;

  localparam logic [FlagSelW-1:0] FLAG_NONE  = 3'd7;
  localparam logic [KeySelW-1:0]  KEY_ABSENT = 2'd3;

  typedef enum logic [2:0] {
    G_IDLE    = 3'd0,
    G_PRESSED = 3'd1,
    G_GAP     = 3'd2,
    G_SECOND  = 3'd3,
    G_LONG    = 3'd4
  } gesture_e;

  typedef struct {
    kgd_req_e              kind;
    logic [KeyLevelsW-1:0] levels;
    logic [KeySelW-1:0]    key;
    logic [FlagSelW-1:0]   flag;
  } key_req_t;

  typedef struct {
    kgd_res_e          kind;
    logic [EvKeyW-1:0] key;
    kgd_event_e        code;
    logic              hit;
    logic              last;
  } key_res_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CFG_SAMPLE_PERIOD;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  kgd_req_if req_if ();
  kgd_res_if res_if ();

  key_gesture_detector_unit #(
    .NUM_KEYS(NUM_KEYS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  logic [PeriodW-1:0]    m_period;
  logic [TimerW-1:0]     m_long;
  logic [TimerW-1:0]     m_gap;
  logic [TimerW-1:0]     m_repeat;
  logic [PeriodW-1:0]    m_presc;
  logic                  m_level [NUM_KEYS];
  gesture_e              m_state [NUM_KEYS];
  logic [TimerW-1:0]     m_timer [NUM_KEYS];
  logic [FlagW-1:0]      m_flags [NUM_KEYS];

  key_req_t              stim_q[$];
  key_res_t              due_q[$];
  logic [KeyLevelsW-1:0] held;
  bit                    quiet_phase;
  int unsigned           stalls_asked;
  int unsigned           stim_made;
  int unsigned           stim_taken;
  int unsigned           errors;
  int unsigned           n_ticks;
  int unsigned           n_checks;
  int unsigned           n_events;
  int unsigned           n_answers;
  int unsigned           n_hits;
  int unsigned           send_wait;
  int unsigned           sink_wait;
  int unsigned           stalls_served;
  int unsigned           stuck_cycles;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Work out the results of one accepted transaction and queue them in order.
  function automatic void predict_keys(key_req_t rq);
    key_res_t         r;
    key_res_t         batch[$];
    logic [FlagW-1:0] fl;
    logic             cur;
    logic             prev;
    logic             emit;
    kgd_event_e       code;
    if (rq.kind == REQ_CHECK) begin
      r.kind = RES_CHECK;
      r.key  = '0;
      r.code = EV_DOWN;
      r.hit  = 1'b0;
      r.last = 1'b1;
      if (rq.key < NUM_KEYS && rq.flag <= FLAG_REPEAT) begin
        if (m_flags[rq.key][rq.flag]) begin
          r.hit = 1'b1;
          if (rq.flag != FLAG_HOLD) m_flags[rq.key][rq.flag] = 1'b0;
        end
      end
      due_q.push_back(r);
      return;
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (m_timer[k] != '0) m_timer[k] = m_timer[k] - 1'b1;
    end
    m_presc = m_presc + 1'b1;
    if (m_presc < m_period) return;
    m_presc = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      prev = m_level[k];
      cur  = rq.levels[k];
      fl   = m_flags[k];
      emit = 1'b0;
      code = EV_DOWN;
      m_level[k]   = cur;
      fl[FLAG_HOLD] = cur;
      if (cur && !prev) begin
        fl[FLAG_DOWN] = 1'b1;
        emit = 1'b1;
        code = EV_DOWN;
      end
      if (!cur && prev) begin
        fl[FLAG_UP] = 1'b1;
        emit = 1'b1;
        code = EV_UP;
      end
      case (m_state[k])
        G_IDLE: begin
          if (cur) begin
            m_timer[k] = m_long;
            m_state[k] = G_PRESSED;
          end
        end
        G_PRESSED: begin
          if (!cur) begin
            m_timer[k] = m_gap;
            m_state[k] = G_GAP;
          end else if (m_timer[k] == '0) begin
            m_timer[k]    = m_repeat;
            fl[FLAG_LONG] = 1'b1;
            emit          = 1'b1;
            code          = EV_LONG;
            m_state[k]    = G_LONG;
          end
        end
        G_GAP: begin
          if (cur) begin
            fl[FLAG_DOUBLE] = 1'b1;
            m_state[k]      = G_SECOND;
          end else if (m_timer[k] == '0) begin
            fl[FLAG_SINGLE] = 1'b1;
            emit            = 1'b1;
            code            = EV_SINGLE;
            m_state[k]      = G_IDLE;
          end
        end
        G_SECOND: begin
          if (!cur) m_state[k] = G_IDLE;
        end
        G_LONG: begin
          if (!cur) begin
            m_state[k] = G_IDLE;
          end else if (m_timer[k] == '0) begin
            m_timer[k]      = m_repeat;
            fl[FLAG_REPEAT] = 1'b1;
            emit            = 1'b1;
            code            = EV_REPEAT;
          end
        end
        default: begin
          m_state[k] = G_IDLE;
        end
      endcase
      m_flags[k] = fl;
      if (emit) begin
        r.kind = RES_EVENT;
        r.key  = EvKeyW'(k);
        r.code = code;
        r.hit  = 1'b0;
        r.last = 1'b0;
        batch.push_back(r);
      end
    end
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_q.push_back(batch[i]);
  endfunction

  function automatic int unsigned pause_len();
    int unsigned roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  task automatic add_tick(logic [KeyLevelsW-1:0] levels);
    key_req_t rq;
    rq.kind   = REQ_TICK;
    rq.levels = levels;
    rq.key    = KeySelW'($urandom());
    rq.flag   = FlagSelW'($urandom());
    stim_q.push_back(rq);
    stim_made++;
  endtask

  task automatic add_check(logic [KeySelW-1:0] key, logic [FlagSelW-1:0] flag);
    key_req_t rq;
    rq.kind   = REQ_CHECK;
    rq.levels = KeyLevelsW'($urandom());
    rq.key    = key;
    rq.flag   = flag;
    stim_q.push_back(rq);
    stim_made++;
  endtask

  // Keys mostly toggle one at a time so that clicks, double clicks and long
  // presses occur; now and then the whole level pattern jumps at random.
  task automatic add_random(int unsigned count, int unsigned flip_odds,
                            int unsigned check_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < check_pct) begin
        add_check(KeySelW'($urandom_range(NUM_KEYS)), FlagSelW'($urandom_range(FLAG_NONE)));
      end else begin
        if ($urandom_range(19) == 0) begin
          held = KeyLevelsW'($urandom());
        end else begin
          for (int k = 0; k < NUM_KEYS; k++) begin
            if ($urandom_range(flip_odds - 1) == 0) held[k] = ~held[k];
          end
        end
        add_tick(held);
      end
    end
  endtask

  task automatic write_reg(kgd_cfg_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_SAMPLE_PERIOD: m_period = value[PeriodW-1:0];
      CFG_LONG_PRESS:    m_long   = value;
      CFG_DOUBLE_GAP:    m_gap    = value;
      CFG_REPEAT:        m_repeat = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_timing(logic [PeriodW-1:0] period, logic [TimerW-1:0] long_t,
                            logic [TimerW-1:0] gap_t, logic [TimerW-1:0] rep_t);
    write_reg(CFG_SAMPLE_PERIOD, CfgDataW'(period));
    write_reg(CFG_LONG_PRESS, long_t);
    write_reg(CFG_DOUBLE_GAP, gap_t);
    write_reg(CFG_REPEAT, rep_t);
  endtask

  // A sampling tick with no events leaves no trace, so the block is given
  // time to finish its key scan after the last result.
  task automatic wait_quiet();
    while (stim_taken != stim_made || due_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_wait    <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (send_wait != 0) begin
        req_if.valid <= 1'b0;
        send_wait    <= send_wait - 1;
      end else if (stim_q.size() != 0) begin
        req_if.valid       <= 1'b1;
        req_if.req_type    <= stim_q[0].kind;
        req_if.key_levels  <= stim_q[0].levels;
        req_if.key_select  <= stim_q[0].key;
        req_if.flag_select <= stim_q[0].flag;
        void'(stim_q.pop_front());
        send_wait <= pause_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : sink_ctl
    int unsigned pick;
    if (!rst_ni) begin
      res_if.ready  <= 1'b0;
      sink_wait     <= 0;
      stalls_served <= 0;
    end else if (stalls_served != stalls_asked) begin
      stalls_served <= stalls_asked;
      sink_wait     <= LONG_HOLD;
      res_if.ready  <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait    <= sink_wait - 1;
      res_if.ready <= 1'b0;
    end else begin
      pick = pause_len();
      if (pick == 0) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        sink_wait    <= pick - 1;
      end
    end
  end

  always @(posedge clk_i) begin : req_mon
    key_req_t seen;
    if (rst_ni && req_if.valid && req_if.ready) begin
      seen.kind   = kgd_req_e'(req_if.req_type);
      seen.levels = req_if.key_levels;
      seen.key    = req_if.key_select;
      seen.flag   = req_if.flag_select;
      if (seen.kind == REQ_CHECK) n_checks++;
      else n_ticks++;
      predict_keys(seen);
      stim_taken++;
    end
  end

  always @(posedge clk_i) begin : res_mon
    key_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: transaction with nothing expected, kind %0d key %0d code %0d hit %0d",
                 $time, res_if.result_kind, res_if.event_key, res_if.event_code,
                 res_if.check_hit);
      end else begin
        want = due_q.pop_front();
        check_field("result_kind", 4'(want.kind), 4'(res_if.result_kind));
        check_field("event_key", 4'(want.key), 4'(res_if.event_key));
        check_field("event_code", 4'(want.code), 4'(res_if.event_code));
        check_field("check_hit", 4'(want.hit), 4'(res_if.check_hit));
        check_field("last", 4'(want.last), 4'(res_if.last));
        if (want.kind == RES_CHECK) begin
          n_answers++;
          if (want.hit) n_hits++;
        end else begin
          n_events++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_TICK;
    req_if.key_levels  = '0;
    req_if.key_select  = '0;
    req_if.flag_select = FLAG_HOLD;
    res_if.ready       = 1'b0;
    stuck_cycles       = 0;
    quiet_phase        = 1'b0;
    held               = '0;
    m_period           = SamplePeriodRst;
    m_long             = LongPressRst;
    m_gap              = DoubleGapRst;
    m_repeat           = RepeatRst;
    m_presc            = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      m_level[k] = 1'b0;
      m_state[k] = G_IDLE;
      m_timer[k] = '0;
      m_flags[k] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Reset timing: the twentieth tick samples all keys pressed at once.
    add_check(KEY_ABSENT, FLAG_HOLD);
    add_check(2'd0, FLAG_NONE);
    held = 3'b111;
    repeat (SamplePeriodRst) add_tick(held);
    add_check(2'd0, FLAG_HOLD);
    add_check(2'd0, FLAG_HOLD);
    add_check(2'd1, FLAG_DOWN);
    add_check(2'd1, FLAG_DOWN);
    wait_quiet();

    // The slowest timing lets the prescaler climb; lowering the period then
    // makes the next tick sample.
    set_timing(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random(30, 4, 20);
    wait_quiet();
    write_reg(CFG_SAMPLE_PERIOD, CfgDataW'(8'd3));
    add_random(60, 3, 25);
    wait_quiet();

    set_timing(8'd0, 16'd0, 16'd0, 16'd0);
    add_random(80, 3, 25);
    wait_quiet();

    set_timing(8'd1, 16'd3, 16'd2, 16'd2);
    add_random(150, 5, 30);
    stalls_asked++;
    wait_quiet();

    quiet_phase = 1'b1;
    set_timing(8'd2, 16'd6, 16'd4, 16'd3);
    add_random(60, 6, 20);
    wait_quiet();
    quiet_phase = 1'b0;

    if (due_q.size() != 0) begin
      errors += due_q.size();
      $display("%0t: %0d expected transactions never arrived", $time, due_q.size());
    end
    $display("Sent %0d ticks and %0d flag checks over six timing settings.", n_ticks, n_checks);
    $display("Compared %0d key events and %0d check answers (%0d hits); %0d errors.",
             n_events, n_answers, n_hits, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kgd_pkg.sv
rtl/kgd_req_if.sv
rtl/kgd_res_if.sv
rtl/kgd_ctrl.sv
rtl/kgd_dpath.sv
rtl/key_gesture_detector_unit.sv
test/tb.sv
